// File: rtl/core/scar_pkg.sv
// ----------------------------------------------------------------------------
// scar_pkg
// Shared constants, types and helpers of the stereo comb/allpass reverb.
// ----------------------------------------------------------------------------
package scar_pkg;

  localparam int SW     = 24;
  localparam int DW     = 32;
  localparam int CW     = 18;
  localparam int MW     = DW + CW;
  localparam int CFG_IW = 3;
  localparam int GW     = 17;

  localparam int COMB_N = 8;
  localparam int AP_N   = 4;
  localparam int SPREAD = 23;

  localparam int COMB_DEPTH = 22232;
  localparam int COMB_AW    = 15;
  localparam int AP_DEPTH   = 3218;
  localparam int TANK_DEPTH = COMB_DEPTH + AP_DEPTH;
  localparam int PD_DEPTH   = 8192;
  localparam int PD_AW      = 13;
  localparam int PD_LW      = 14;
  localparam int CPOS_W     = 11;
  localparam int APOS_W     = 10;
  localparam int CLR_W      = 15;

  localparam logic [CPOS_W-1:0] COMB_TUNE [COMB_N] = '{
    11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617
  };
  localparam logic [APOS_W-1:0] AP_TUNE [AP_N] = '{10'd556, 10'd441, 10'd341, 10'd225};

  // left channel first, then right
  localparam logic [COMB_AW-1:0] COMB_BASE [2*COMB_N] = '{
    15'd0,     15'd1116,  15'd2304,  15'd3581,  15'd4937,  15'd6359,  15'd7850,  15'd9407,
    15'd11024, 15'd12163, 15'd13374, 15'd14674, 15'd16053, 15'd17498, 15'd19012, 15'd20592
  };
  // allpass lines sit above the comb lines in the same memory
  localparam logic [COMB_AW-1:0] AP_BASE [2*AP_N] = '{
    15'd22232, 15'd22788, 15'd23229, 15'd23570, 15'd23795, 15'd24374, 15'd24838, 15'd25202
  };

  localparam logic signed [CW-1:0] GAIN_ONE   = 18'sd32768;
  localparam logic signed [CW-1:0] Q16_ONE    = 18'sd65536;
  localparam logic signed [CW-1:0] GAIN_SCALE = 18'sd983;
  localparam logic [GW-1:0]        GAIN_MAX   = 17'd32768;

  localparam logic signed [MW-1:0] SAT_HI = MW'(2**(SW-1) - 1);
  localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - MW'(1);

  typedef enum logic [CFG_IW-1:0] {
    REG_WET, REG_DRY, REG_FB, REG_DAMP, REG_APG, REG_PD, REG_WIDTH, REG_FILT
  } cfg_idx_t;

  typedef struct packed {
    logic [GW-1:0]    wet;
    logic [GW-1:0]    dry;
    logic [GW-1:0]    fb;
    logic [GW-1:0]    damp;
    logic [GW-1:0]    apg;
    logic [GW-1:0]    width;
    logic [PD_LW-1:0] pd_len;
    logic [15:0]      lc;
    logic [15:0]      hc;
  } scar_cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } scar_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PD_RD, S_PD_WR,
    S_C_RD, S_C_MUL0, S_C_MUL1, S_C_UPD, S_C_WR,
    S_A_RD, S_A_MUL, S_A_WR,
    S_G_MUL, S_LC_MUL, S_LC_UPD, S_HC_MUL0, S_HC_MUL1, S_HC_UPD, S_CH_END,
    S_W_A, S_W_B, S_W_C, S_W_D, S_W_E,
    S_M_L1, S_M_R0, S_M_R1, S_M_END, S_DONE
  } scar_state_t;

  function automatic logic signed [SW-1:0] sat(input logic signed [MW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[SW-1:0];
    else if (v < SAT_LO) r = SAT_LO[SW-1:0];
    else r = v[SW-1:0];
    return r;
  endfunction

endpackage

// File: rtl/core/scar_ram.sv
// ----------------------------------------------------------------------------
// scar_ram
// Simple dual-port synchronous ram, one write and one registered read.
// ----------------------------------------------------------------------------
module scar_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/scar_engine.sv
// ----------------------------------------------------------------------------
// scar_engine
// Sequencer and shared multiply-accumulate walking the delay memories.
// ----------------------------------------------------------------------------
module scar_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [scar_pkg::SW-1:0] xin_left,
  input  logic signed [scar_pkg::SW-1:0] xin_right,
  input  scar_pkg::scar_cfg_t            cfg,
  input  logic                           out_free,
  output scar_pkg::scar_stat_t           stat,
  output logic signed [scar_pkg::SW-1:0] res_left,
  output logic signed [scar_pkg::SW-1:0] res_right
);
  import scar_pkg::*;

  scar_state_t state_r, state_nxt;

  logic [CLR_W-1:0]        clr_r;
  logic                    ch_r;
  logic [2:0]              idx_r;
  logic signed [MW-1:0]    m_r, m_nxt;
  logic signed [SW-1:0]    xin_r [2];
  logic signed [SW-1:0]    tank_in_r [2];
  logic signed [DW-1:0]    sum_r;
  logic signed [SW-1:0]    tap_r;
  logic signed [DW-1:0]    lp_r [2*COMB_N];
  logic signed [DW-1:0]    lc_r [2];
  logic signed [DW-1:0]    hc_r [2];
  logic signed [DW-1:0]    yv_r;
  logic signed [DW-1:0]    yo_r [2];
  logic signed [DW-1:0]    wa_r, wb_r;
  logic signed [SW-1:0]    res_r [2];
  logic [CPOS_W-1:0]       cpos_r [2*COMB_N];
  logic [APOS_W-1:0]       apos_r [2*AP_N];
  logic [PD_AW-1:0]        ppos_r;

  logic signed [DW-1:0]    mul_a;
  logic signed [CW-1:0]    mul_b;
  logic signed [MW-1:0]    prod;
  logic                    acc_en, shift16;

  logic [3:0]              ck;
  logic [2:0]              ak;
  logic [CPOS_W-1:0]       clen, cpos, cpos_inc;
  logic [APOS_W-1:0]       alen, apos, apos_inc;
  logic [COMB_AW-1:0]      caddr;
  logic [COMB_AW-1:0]      aaddr;
  logic signed [MW-1:0]    rnd15, rnd16;
  logic signed [DW-1:0]    r15, r16, yg, lcn;
  logic [PD_LW-1:0]        ppos_inc;

  logic                    tank_we, pd_we;
  logic [COMB_AW-1:0]      tank_waddr, tank_raddr;
  logic [PD_AW-1:0]        pd_waddr;
  logic [SW-1:0]           tank_wdata;
  logic [2*SW-1:0]         pd_wdata;
  logic [SW-1:0]           tank_rdata;
  logic [2*SW-1:0]         pd_rdata;

  scar_ram #(.DEPTH(TANK_DEPTH), .AW(COMB_AW), .WIDTH(SW)) u_tank_mem (
    .clk(clk), .we(tank_we), .waddr(tank_waddr), .wdata(tank_wdata),
    .raddr(tank_raddr), .rdata(tank_rdata)
  );
  scar_ram #(.DEPTH(PD_DEPTH), .AW(PD_AW), .WIDTH(2*SW)) u_pd_mem (
    .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
    .raddr(ppos_r), .rdata(pd_rdata)
  );

  // addressing
  assign ck         = {ch_r, idx_r};
  assign ak         = {ch_r, idx_r[1:0]};
  assign clen       = COMB_TUNE[idx_r] + (ch_r ? CPOS_W'(SPREAD) : '0);
  assign alen       = AP_TUNE[idx_r[1:0]] + (ch_r ? APOS_W'(SPREAD) : '0);
  assign cpos       = cpos_r[ck];
  assign apos       = apos_r[ak];
  assign cpos_inc   = (cpos + 1'b1 == clen) ? '0 : cpos + 1'b1;
  assign apos_inc   = (apos + 1'b1 == alen) ? '0 : apos + 1'b1;
  assign caddr      = COMB_BASE[ck] + COMB_AW'(cpos);
  assign aaddr      = AP_BASE[ak] + COMB_AW'(apos);
  assign tank_raddr = (state_r == S_A_RD) ? aaddr : caddr;
  assign ppos_inc   = ({1'b0, ppos_r} + 1'b1 >= cfg.pd_len) ? '0 : {1'b0, ppos_r} + 1'b1;

  // rounding is a floor shift on the biased accumulator
  assign rnd15 = m_r >>> 15;
  assign rnd16 = m_r >>> 16;
  assign r15   = $signed(rnd15[DW-1:0]);
  assign r16   = $signed(rnd16[DW-1:0]);
  assign yg    = DW'(sat(rnd16));
  assign lcn   = lc_r[ch_r] + r16;

  assign prod  = mul_a * mul_b;
  assign m_nxt = (acc_en ? m_r : (shift16 ? MW'(32768) : MW'(16384))) + prod;

  assign res_left  = res_r[0];
  assign res_right = res_r[1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_r == CLR_W'(TANK_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (start) state_nxt = (cfg.pd_len != '0) ? S_PD_RD : S_C_RD;
      S_PD_RD:   state_nxt = S_PD_WR;
      S_PD_WR:   state_nxt = S_C_RD;
      S_C_RD:    state_nxt = S_C_MUL0;
      S_C_MUL0:  state_nxt = S_C_MUL1;
      S_C_MUL1:  state_nxt = S_C_UPD;
      S_C_UPD:   state_nxt = S_C_WR;
      S_C_WR:    state_nxt = (idx_r == 3'(COMB_N - 1)) ? S_A_RD : S_C_RD;
      S_A_RD:    state_nxt = S_A_MUL;
      S_A_MUL:   state_nxt = S_A_WR;
      S_A_WR:    state_nxt = (idx_r[1:0] == 2'(AP_N - 1)) ? S_G_MUL : S_A_RD;
      S_G_MUL:   state_nxt = S_LC_MUL;
      S_LC_MUL: begin
        if (cfg.lc != '0) state_nxt = S_LC_UPD;
        else if (cfg.hc != '0) state_nxt = S_HC_MUL0;
        else state_nxt = S_CH_END;
      end
      S_LC_UPD:  state_nxt = (cfg.hc != '0) ? S_HC_MUL0 : S_CH_END;
      S_HC_MUL0: state_nxt = S_HC_MUL1;
      S_HC_MUL1: state_nxt = S_HC_UPD;
      S_HC_UPD:  state_nxt = S_CH_END;
      S_CH_END:  state_nxt = ch_r ? S_W_A : S_C_RD;
      S_W_A:     state_nxt = S_W_B;
      S_W_B:     state_nxt = S_W_C;
      S_W_C:     state_nxt = S_W_D;
      S_W_D:     state_nxt = S_W_E;
      S_W_E:     state_nxt = S_M_L1;
      S_M_L1:    state_nxt = S_M_R0;
      S_M_R0:    state_nxt = S_M_R1;
      S_M_R1:    state_nxt = S_M_END;
      S_M_END:   state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    acc_en     = 1'b0;
    shift16    = 1'b0;
    tank_we    = 1'b0;
    pd_we      = 1'b0;
    tank_waddr = caddr;
    pd_waddr   = ppos_r;
    tank_wdata = sat(MW'(tank_in_r[ch_r]) + rnd15);
    pd_wdata   = {xin_r[1], xin_r[0]};
    stat.idle  = (state_r == S_IDLE);
    stat.done  = (state_r == S_DONE) && out_free;
    case (state_r)
      S_CLEAR: begin
        tank_we    = 1'b1;
        pd_we      = (clr_r < CLR_W'(PD_DEPTH));
        tank_waddr = clr_r;
        pd_waddr   = clr_r[PD_AW-1:0];
        tank_wdata = '0;
        pd_wdata   = '0;
      end
      S_PD_WR:   pd_we = 1'b1;
      S_C_MUL0: begin
        mul_a = DW'($signed(tank_rdata));
        mul_b = GAIN_ONE - $signed({1'b0, cfg.damp});
      end
      S_C_MUL1: begin
        mul_a  = lp_r[ck];
        mul_b  = $signed({1'b0, cfg.damp});
        acc_en = 1'b1;
      end
      S_C_UPD: begin
        mul_a = r15;
        mul_b = $signed({1'b0, cfg.fb});
      end
      S_C_WR:    tank_we = 1'b1;
      S_A_MUL: begin
        mul_a = DW'($signed(tank_rdata));
        mul_b = $signed({1'b0, cfg.apg});
      end
      S_A_WR: begin
        tank_we    = 1'b1;
        tank_waddr = aaddr;
        tank_wdata = sat(MW'(sum_r) + rnd15);
      end
      S_G_MUL: begin
        mul_a   = sum_r;
        mul_b   = GAIN_SCALE;
        shift16 = 1'b1;
      end
      S_LC_MUL: begin
        mul_a   = yg - lc_r[ch_r];
        mul_b   = $signed({2'b00, cfg.lc});
        shift16 = 1'b1;
      end
      S_HC_MUL0: begin
        mul_a   = yv_r;
        mul_b   = Q16_ONE - $signed({2'b00, cfg.hc});
        shift16 = 1'b1;
      end
      S_HC_MUL1: begin
        mul_a   = hc_r[ch_r];
        mul_b   = $signed({2'b00, cfg.hc});
        acc_en  = 1'b1;
        shift16 = 1'b1;
      end
      S_W_A: begin
        mul_a = yo_r[0];
        mul_b = $signed({1'b0, cfg.width});
      end
      S_W_B: begin
        mul_a = yo_r[1];
        mul_b = $signed({1'b0, cfg.width});
      end
      S_W_C: begin
        mul_a = r15;
        mul_b = GAIN_ONE - $signed({1'b0, cfg.width});
      end
      S_W_D: begin
        mul_a = wa_r;
        mul_b = GAIN_ONE - $signed({1'b0, cfg.width});
      end
      S_W_E: begin
        mul_a = DW'(xin_r[0]);
        mul_b = $signed({1'b0, cfg.dry});
      end
      S_M_L1: begin
        mul_a  = yo_r[0];
        mul_b  = $signed({1'b0, cfg.wet});
        acc_en = 1'b1;
      end
      S_M_R0: begin
        mul_a = DW'(xin_r[1]);
        mul_b = $signed({1'b0, cfg.dry});
      end
      S_M_R1: begin
        mul_a  = yo_r[1];
        mul_b  = $signed({1'b0, cfg.wet});
        acc_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ppos_r  <= '0;
      for (int i = 0; i < 2*COMB_N; i++) begin
        cpos_r[i] <= '0;
        lp_r[i]   <= '0;
      end
      for (int i = 0; i < 2*AP_N; i++) begin
        apos_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        lc_r[i] <= '0;
        hc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          if (start) begin
            xin_r[0]     <= xin_left;
            xin_r[1]     <= xin_right;
            tank_in_r[0] <= xin_left;
            tank_in_r[1] <= xin_right;
            ch_r         <= 1'b0;
            idx_r        <= '0;
            sum_r        <= '0;
          end
        end
        S_PD_WR: begin
          tank_in_r[0] <= $signed(pd_rdata[SW-1:0]);
          tank_in_r[1] <= $signed(pd_rdata[2*SW-1:SW]);
          ppos_r       <= ppos_inc[PD_AW-1:0];
        end
        S_C_MUL0: tap_r <= $signed(tank_rdata);
        S_C_UPD:  lp_r[ck] <= r15;
        S_C_WR: begin
          sum_r      <= sum_r + DW'(tap_r);
          cpos_r[ck] <= cpos_inc;
          idx_r      <= (idx_r == 3'(COMB_N - 1)) ? '0 : idx_r + 1'b1;
        end
        S_A_MUL: tap_r <= $signed(tank_rdata);
        S_A_WR: begin
          sum_r      <= DW'(tap_r) - sum_r;
          apos_r[ak] <= apos_inc;
          idx_r      <= (idx_r[1:0] == 2'(AP_N - 1)) ? '0 : idx_r + 1'b1;
        end
        S_LC_MUL: yv_r <= yg;
        S_LC_UPD: begin
          lc_r[ch_r] <= lcn;
          yv_r       <= yv_r - lcn;
        end
        S_HC_UPD: begin
          hc_r[ch_r] <= r16;
          yv_r       <= r16;
        end
        S_CH_END: begin
          yo_r[ch_r] <= yv_r;
          if (!ch_r) begin
            ch_r  <= 1'b1;
            idx_r <= '0;
            sum_r <= '0;
          end
        end
        S_W_B:   wa_r <= r15;
        S_W_C:   wb_r <= r15;
        S_W_D:   yo_r[0] <= wa_r + r15;
        S_W_E:   yo_r[1] <= wb_r + r15;
        S_M_R0:  res_r[0] <= sat(rnd15);
        S_M_END: res_r[1] <= sat(rnd15);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/stereo_comb_allpass_reverb_top.sv
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_top
// Stereo comb/allpass reverb with predelay, tone filters, width and mix.
// ----------------------------------------------------------------------------
// One stereo word in gives one stereo word out. After reset the block clears
// its delay memories before in_tready rises. A word then holds the engine from
// its acceptance until its result is passed on and the engine is back in idle:
// per channel every comb and then every allpass, then the gain and the channel
// hand-over; after both channels the width and mix stages. Predelay adds a read
// and a write of its memory, the low cut an update and the high cut two
// multiplies and an update per channel when in use; every comb, allpass and
// post stage walks through one shared multiply-accumulate and the one read and
// one write port of each delay memory. A finished result sits in the output
// register while the next word is accepted; a result still waiting there when
// the next one is ready holds the engine until it is taken.
module stereo_comb_allpass_reverb_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // left_in, right_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // left_out, right_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import scar_pkg::*;

  logic [15:0]       wet_r, dry_r, fb_r, damp_r, apg_r, width_r;
  logic [PD_LW-1:0]  pd_r;
  logic [31:0]       filt_r;
  logic              out_valid_r;
  logic [2*SW-1:0]   out_data_r;
  scar_cfg_t         cfg;
  scar_stat_t        stat;
  logic              out_free;
  logic signed [SW-1:0] res_left, res_right;

  function automatic logic [GW-1:0] clamp_gain(input logic [15:0] v);
    return ({1'b0, v} > GAIN_MAX) ? GAIN_MAX : {1'b0, v};
  endfunction

  assign cfg.wet    = clamp_gain(wet_r);
  assign cfg.dry    = clamp_gain(dry_r);
  assign cfg.fb     = clamp_gain(fb_r);
  assign cfg.damp   = clamp_gain(damp_r);
  assign cfg.apg    = clamp_gain(apg_r);
  assign cfg.width  = clamp_gain(width_r);
  assign cfg.pd_len = (pd_r > PD_LW'(PD_DEPTH)) ? PD_LW'(PD_DEPTH) : pd_r;
  assign cfg.lc     = filt_r[15:0];
  assign cfg.hc     = filt_r[31:16];

  assign cfg_ready  = 1'b1;
  assign in_tready  = stat.idle;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  scar_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .start(in_tvalid && in_tready),
    .xin_left($signed(in_tdata[SW-1:0])),
    .xin_right($signed(in_tdata[2*SW-1:SW])),
    .cfg(cfg), .out_free(out_free), .stat(stat),
    .res_left(res_left), .res_right(res_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_r   <= 16'd10923;
      dry_r   <= 16'd16384;
      fb_r    <= 16'd27525;
      damp_r  <= 16'd6554;
      apg_r   <= 16'd16384;
      pd_r    <= '0;
      width_r <= 16'd32768;
      filt_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_WET:   wet_r   <= cfg_data[15:0];
        REG_DRY:   dry_r   <= cfg_data[15:0];
        REG_FB:    fb_r    <= cfg_data[15:0];
        REG_DAMP:  damp_r  <= cfg_data[15:0];
        REG_APG:   apg_r   <= cfg_data[15:0];
        REG_PD:    pd_r    <= cfg_data[PD_LW-1:0];
        REG_WIDTH: width_r <= cfg_data[15:0];
        REG_FILT:  filt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stat.done) begin
      out_data_r <= {res_right, res_left};
    end
  end

endmodule

// File: rtl/core/scar_checker.sv
// ----------------------------------------------------------------------------
// scar_checker
// Port-level checks of the reverb, bound to the top level.
// ----------------------------------------------------------------------------
module scar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without a word in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind stereo_comb_allpass_reverb_top scar_checker u_scar_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the stereo comb/allpass reverb. A bit-true model of both tanks
// predicts every output word; random stimulus and handshake idling run across
// several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scar_pkg::*;

  localparam int PD_MAX = 8192;
  localparam int CLEN_MAX = 1640;
  localparam int ALEN_MAX = 579;
  localparam longint SMAX = 64'sd8388607;
  localparam longint SMIN = -64'sd8388608;

  class reverb_scoreboard;
    longint unsigned regs [8];
    longint comb_mem [2][8][CLEN_MAX];
    longint comb_lp [2][8];
    int comb_pos [2][8];
    longint ap_mem [2][4][ALEN_MAX];
    int ap_pos [2][4];
    longint pd_mem [2][PD_MAX];
    int pd_pos;
    longint lc_s [2];
    longint hc_s [2];
    logic [47:0] pending [$];
    int mismatches;
    int comb_len [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    int ap_len [4] = '{556, 441, 341, 225};

    function new();
      regs = '{10923, 16384, 27525, 6554, 16384, 0, 32768, 0};
      mismatches = 0;
      pd_pos = 0;
      foreach (comb_mem[c, i, j]) comb_mem[c][i][j] = 0;
      foreach (comb_lp[c, i]) begin
        comb_lp[c][i] = 0;
        comb_pos[c][i] = 0;
      end
      foreach (ap_mem[c, i, j]) ap_mem[c][i][j] = 0;
      foreach (ap_pos[c, i]) ap_pos[c][i] = 0;
      foreach (pd_mem[c, j]) pd_mem[c][j] = 0;
      lc_s = '{0, 0};
      hc_s = '{0, 0};
    endfunction

    function longint rnd(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x);
      return x > SMAX ? SMAX : (x < SMIN ? SMIN : x);
    endfunction

    function longint gain(int i);
      return regs[i] > 32768 ? 32768 : longint'(regs[i]);
    endfunction

    function void write_reg(cfg_idx_t idx, longint unsigned v);
      regs[idx] = (idx == REG_PD) ? (v & 64'h3fff) : (idx == REG_FILT) ? (v & 64'hffffffff)
                : (v & 64'hffff);
    endfunction

    function longint tank(int ch, longint x);
      longint f, d, g, acc, o, s, b, c, h;
      int len, p;
      f = gain(REG_FB);
      d = gain(REG_DAMP);
      g = gain(REG_APG);
      acc = 0;
      for (int i = 0; i < 8; i++) begin
        len = comb_len[i] + (ch ? SPREAD : 0);
        p = comb_pos[ch][i] >= len ? 0 : comb_pos[ch][i];
        o = comb_mem[ch][i][p];
        s = rnd(o * (32768 - d) + comb_lp[ch][i] * d, 15);
        comb_lp[ch][i] = s;
        comb_mem[ch][i][p] = clamp(x + rnd(s * f, 15));
        comb_pos[ch][i] = (p + 1 >= len) ? 0 : p + 1;
        acc += o;
      end
      for (int i = 0; i < 4; i++) begin
        len = ap_len[i] + (ch ? SPREAD : 0);
        p = ap_pos[ch][i] >= len ? 0 : ap_pos[ch][i];
        b = ap_mem[ch][i][p];
        ap_mem[ch][i][p] = clamp(acc + rnd(b * g, 15));
        ap_pos[ch][i] = (p + 1 >= len) ? 0 : p + 1;
        acc = b - acc;
      end
      acc = clamp(rnd(acc * 983, 16));
      c = longint'(regs[REG_FILT] & 64'hffff);
      h = longint'((regs[REG_FILT] >> 16) & 64'hffff);
      if (c != 0) begin
        lc_s[ch] += rnd((acc - lc_s[ch]) * c, 16);
        acc = acc - lc_s[ch];
      end
      if (h != 0) begin
        hc_s[ch] = rnd(acc * (65536 - h) + hc_s[ch] * h, 16);
        acc = hc_s[ch];
      end
      return acc;
    endfunction

    function void note_input(logic [47:0] word);
      longint xin [2], x [2], y [2], a, b, w, cr, wet, dry, len;
      logic [23:0] res [2];
      xin[0] = longint'($signed(word[23:0]));
      xin[1] = longint'($signed(word[47:24]));
      x = xin;
      len = regs[REG_PD] > PD_MAX ? PD_MAX : longint'(regs[REG_PD]);
      if (len > 0) begin
        for (int ch = 0; ch < 2; ch++) begin
          x[ch] = pd_mem[ch][pd_pos];
          pd_mem[ch][pd_pos] = xin[ch];
        end
        pd_pos = (pd_pos + 1 >= len) ? 0 : pd_pos + 1;
      end
      for (int ch = 0; ch < 2; ch++) y[ch] = tank(ch, x[ch]);
      w = gain(REG_WIDTH);
      cr = 32768 - w;
      a = rnd(y[0] * w, 15);
      b = rnd(y[1] * w, 15);
      y[0] = a + rnd(b * cr, 15);
      y[1] = b + rnd(a * cr, 15);
      wet = gain(REG_WET);
      dry = gain(REG_DRY);
      for (int ch = 0; ch < 2; ch++)
        res[ch] = 24'(clamp(rnd(xin[ch] * dry + y[ch] * wet, 15)));
      pending.push_back({res[1], res[0]});
    endfunction

    function void check_output(logic [47:0] word);
      logic [47:0] exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("output word %h with none expected", word);
        return;
      end
      exp_w = pending.pop_front();
      if (exp_w[23:0] !== word[23:0] || exp_w[47:24] !== word[47:24]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: left exp %h got %h, right exp %h got %h",
                   exp_w[23:0], word[23:0], exp_w[47:24], word[47:24]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  reverb_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;
  bit done_flag = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stereo_comb_allpass_reverb_top dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3_000_000 && !done_flag) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(logic [23:0] l, logic [23:0] r);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {r, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input({r, l});
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setting();
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(3))
        0: write_reg(cfg_idx_t'(i), 32'd0);
        1: write_reg(cfg_idx_t'(i), (i == REG_FILT) ? $urandom() : $urandom_range(32768));
        2: write_reg(cfg_idx_t'(i), (i == REG_PD) ? 32'h3fff :
                                    (i == REG_FILT) ? 32'hffffffff : 32'hffff);
        default: write_reg(cfg_idx_t'(i), (i == REG_PD) ? $urandom_range(40) :
                                          (i == REG_FILT) ? $urandom() : 32'd32768);
      endcase
    end
  endtask

  task automatic random_words(int n);
    logic [23:0] l, r;
    for (int k = 0; k < n; k++) begin
      l = 24'($urandom());
      r = ($urandom_range(9) == 0) ? l : 24'($urandom());
      if ($urandom_range(7) == 0) l = $urandom_range(1) ? 24'h7fffff : 24'h800000;
      send_word(l, r);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_word(24'h7fffff, 24'h7fffff);
    send_word(24'h800000, 24'h800000);
    send_word(24'h000000, 24'h7fffff);
    send_word(24'h7fffff, 24'h800000);
    for (int k = 0; k < 6; k++) send_word(24'h000000, 24'h000000);
    drain();
    write_reg(REG_FB, 32'd32768);
    write_reg(REG_DAMP, 32'd0);
    write_reg(REG_APG, 32'hffff);
    write_reg(REG_WET, 32'd32768);
    write_reg(REG_DRY, 32'd0);
    write_reg(REG_PD, 32'd3);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_FILT, 32'hffff_0001);
    send_word(24'h7fffff, 24'h800000);
    send_word(24'h555555, 24'haaaaaa);
    for (int k = 0; k < 4; k++) send_word(24'h000000, 24'h000000);
    drain();
    write_reg(REG_PD, 32'h3fff);
    write_reg(REG_FILT, 32'h0001_ffff);
    write_reg(REG_WET, 32'hffff);
    write_reg(REG_DRY, 32'hffff);
    send_word(24'h7fffff, 24'h7fffff);
    send_word(24'h800000, 24'h800000);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      send_idle = (ph < 3) ? 26 : (ph < 6) ? 71 : 0;
      recv_idle = (ph < 3) ? 71 : (ph < 6) ? 26 : 0;
      random_setting();
      random_words(70);
      drain();
      random_words(70);
      drain();
    end
    done_flag = 1'b1;
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: stereo_comb_allpass_reverb_top.f
rtl/core/scar_pkg.sv
rtl/core/scar_ram.sv
rtl/core/scar_engine.sv
rtl/core/stereo_comb_allpass_reverb_top.sv
rtl/core/scar_checker.sv
tb/sv/tb_top.sv
